// ----- rtl/esg_pkg.sv -----
// Shared types, constants and the quarter-wave sine table of the tone generator.
package esg_pkg;

  localparam int PHASE_W = 32;
  localparam int FRAME_W = 16;
  localparam int AMP_W = 16;
  localparam int SAMPLE_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_FRAMES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd2;

  localparam int SINE_DEPTH = 256;
  localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
  localparam int SINE_ADDR_W = SINE_IDX_W + 1;
  localparam int SINE_W = 15;

  localparam int ATTACK_CAP = 96;
  localparam int ATTACK_W = $clog2(ATTACK_CAP + 1);

  localparam int DIV_W = 16;
  localparam int DIV_STEPS = 2 * DIV_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int ENV_W = DIV_W + 1;

  localparam int MUL_W = 31;
  localparam int MUL_CNT_W = $clog2(MUL_W);
  localparam int MAG_SHIFT = 47 - MUL_W;
  localparam int MAG_W = 15;
  localparam logic [MUL_W-1:0] TONE_SCALE = 31'd26000;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_ENV,
    ST_MUL_OUT,
    ST_FIN
  } esg_state_t;

  typedef logic [SINE_W-1:0] sine_lut_t [0:SINE_DEPTH];

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] q;
    logic signed [63:0] sum;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      x = (HALF_PI_Q30 * 64'(k)) / SINE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum = sum - $signed(term);
      if (sum < 0) begin
        sum = 64'sd0;
      end
      if (sum > (64'sd1 <<< 30)) begin
        sum = 64'sd1 <<< 30;
      end
      q = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      lut[k] = q[SINE_W-1:0];
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

// ----- rtl/esg_div.sv -----
// Bit-serial restoring divider for the envelope: (num << 16) / den, one quotient bit a cycle.
module esg_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [esg_pkg::DIV_W-1:0]    num,
  input  logic [esg_pkg::DIV_W-1:0]    den,
  output logic                         busy,
  output logic [esg_pkg::ENV_W-1:0]    quo
);
  import esg_pkg::*;

  logic                  busy_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [DIV_W-1:0]      rem_r;
  logic [DIV_STEPS-1:0]  dvd_r;
  logic [DIV_W-1:0]      den_r;

  logic [DIV_W:0]        trial;
  logic [DIV_W:0]        diff;
  logic                  ge;

  assign trial = {rem_r, dvd_r[DIV_STEPS-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= {num, {DIV_W{1'b0}}};
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      dvd_r <= {dvd_r[DIV_STEPS-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quo  = dvd_r[ENV_W-1:0];

endmodule

// ----- rtl/esg_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit a cycle, 31 by 31 bits.
module esg_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [esg_pkg::MUL_W-1:0]   a,
  input  logic [esg_pkg::MUL_W-1:0]   b,
  output logic                        busy,
  output logic [esg_pkg::MUL_W-1:0]   prod_hi,
  output logic [esg_pkg::MUL_W-1:0]   prod_lo
);
  import esg_pkg::*;

  logic                  busy_r;
  logic [MUL_CNT_W-1:0]  cnt_r;
  logic [MUL_W-1:0]      a_r;
  logic [MUL_W-1:0]      hi_r;
  logic [MUL_W-1:0]      lo_r;
  logic [MUL_W:0]        sum;

  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == MUL_CNT_W'(MUL_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      hi_r <= sum[MUL_W:1];
      lo_r <= {sum[0], lo_r[MUL_W-1:1]};
    end
  end

  assign busy    = busy_r;
  assign prod_hi = hi_r;
  assign prod_lo = lo_r;

endmodule

// ----- rtl/enveloped_sine_tone_generator_top.sv -----
// Tone generator: each input item yields one sample of a sine tone shaped by a linear
// attack/decay envelope. An item that produces a tone frame runs through the bit-serial
// envelope divider, then makes two passes through the shared bit-serial multiplier (sine
// times envelope, then times amplitude scaled by 26000, which is formed while the divider
// runs). The input stalls while an item is in work and takes the next item from the cycle
// after a result is loaded; the output register holds a finished result until it is taken,
// and the next item may be accepted meanwhile. Configuration writes are always ready and
// take effect on the next item.
module enveloped_sine_tone_generator_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_start_req,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [esg_pkg::SAMPLE_W-1:0] out_sample,
  output logic                               out_last,
  output logic                               out_active,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [esg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [esg_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import esg_pkg::*;

  esg_state_t state_r, state_nxt;

  logic [PHASE_W-1:0]  phase_step_r;
  logic [FRAME_W-1:0]  tone_frames_r;
  logic [AMP_W-1:0]    amplitude_r;

  logic [PHASE_W-1:0]  phase_acc_r;
  logic [FRAME_W-1:0]  frame_index_r;
  logic                tone_active_r;

  logic [SINE_W-1:0]   sine_mag_r;
  logic                neg_r;
  logic                last_r;
  logic [MUL_W-1:0]    k_r;

  logic signed [SAMPLE_W-1:0] res_sample_r;
  logic                res_last_r;
  logic                res_active_r;

  logic                out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                out_last_r;
  logic                out_active_r;

  logic                accept;
  logic                out_free;
  logic [PHASE_W-1:0]  phase_eff;
  logic [FRAME_W-1:0]  idx_eff;
  logic                act;
  logic                last_now;
  logic [SINE_IDX_W-1:0]  sine_idx;
  logic [SINE_ADDR_W-1:0] sine_addr;
  logic [FRAME_W-3:0]  frames_q;
  logic [ATTACK_W-1:0] attack;
  logic [FRAME_W-1:0]  attack_ext;
  logic                in_attack;
  logic [DIV_W-1:0]    div_num;
  logic [DIV_W-1:0]    div_den;

  logic                div_start;
  logic                div_busy;
  logic [ENV_W-1:0]    env;
  logic                mul_start;
  logic                mul_busy;
  logic [MUL_W-1:0]    mul_a;
  logic [MUL_W-1:0]    mul_b;
  logic [MUL_W-1:0]    prod_hi;
  logic [MUL_W-1:0]    prod_lo;
  logic                load_k;
  logic                load_res;
  logic                load_out;
  logic [MAG_W-1:0]    mag;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign phase_eff = in_start_req ? '0 : phase_acc_r;
  assign idx_eff   = in_start_req ? '0 : frame_index_r;
  assign act       = (in_start_req ? (tone_frames_r != '0) : tone_active_r)
                     && (idx_eff < tone_frames_r);
  assign last_now  = (idx_eff + 1'b1) == tone_frames_r;

  assign sine_idx  = phase_eff[PHASE_W-3 -: SINE_IDX_W];
  assign sine_addr = phase_eff[PHASE_W-2]
                     ? SINE_ADDR_W'(SINE_DEPTH) - {1'b0, sine_idx}
                     : {1'b0, sine_idx};

  assign frames_q   = tone_frames_r[FRAME_W-1:2];
  assign attack     = (frames_q > (FRAME_W-2)'(ATTACK_CAP)) ? ATTACK_W'(ATTACK_CAP)
                                                           : frames_q[ATTACK_W-1:0];
  assign attack_ext = FRAME_W'(attack);
  assign in_attack  = idx_eff < attack_ext;
  assign div_num    = in_attack ? idx_eff : tone_frames_r - idx_eff;
  assign div_den    = in_attack ? attack_ext : tone_frames_r - attack_ext;

  assign mag = prod_hi[MAG_SHIFT +: MAG_W];

  esg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (env)
  );

  esg_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .busy    (mul_busy),
    .prod_hi (prod_hi),
    .prod_lo (prod_lo)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = act ? ST_DIV : ST_FIN;
        end
      end
      ST_DIV: begin
        if (!div_busy && !mul_busy) begin
          state_nxt = ST_MUL_ENV;
        end
      end
      ST_MUL_ENV: begin
        if (!mul_busy) begin
          state_nxt = ST_MUL_OUT;
        end
      end
      ST_MUL_OUT: begin
        if (!mul_busy) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    load_k    = 1'b0;
    load_res  = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        div_start = accept && act;
        mul_start = accept && act;
        mul_a     = MUL_W'(amplitude_r);
        mul_b     = TONE_SCALE;
      end
      ST_DIV: begin
        mul_start = !div_busy && !mul_busy;
        load_k    = !div_busy && !mul_busy;
        mul_a     = MUL_W'(sine_mag_r);
        mul_b     = MUL_W'(env);
      end
      ST_MUL_ENV: begin
        mul_start = !mul_busy;
        mul_a     = prod_lo;
        mul_b     = k_r;
      end
      ST_MUL_OUT: begin
        load_res = !mul_busy;
      end
      ST_FIN: begin
        load_out = out_free;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      phase_step_r  <= '0;
      tone_frames_r <= '0;
      amplitude_r   <= '0;
      phase_acc_r   <= '0;
      frame_index_r <= '0;
      tone_active_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PHASE_STEP:  phase_step_r  <= cfg_data[PHASE_W-1:0];
          REG_TONE_FRAMES: tone_frames_r <= cfg_data[FRAME_W-1:0];
          REG_AMPLITUDE:   amplitude_r   <= cfg_data[AMP_W-1:0];
          default:         phase_step_r  <= phase_step_r;
        endcase
      end
      if (accept) begin
        if (act) begin
          phase_acc_r   <= phase_eff + phase_step_r;
          frame_index_r <= idx_eff + 1'b1;
          tone_active_r <= !last_now;
        end else begin
          phase_acc_r   <= phase_eff;
          frame_index_r <= idx_eff;
          tone_active_r <= 1'b0;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sine_mag_r   <= SINE_LUT[sine_addr];
      neg_r        <= phase_eff[PHASE_W-1];
      last_r       <= last_now;
      res_sample_r <= '0;
      res_last_r   <= 1'b0;
      res_active_r <= 1'b0;
    end
    if (load_k) begin
      k_r <= prod_lo;
    end
    if (load_res) begin
      res_sample_r <= neg_r ? -$signed(SAMPLE_W'(mag)) : $signed(SAMPLE_W'(mag));
      res_last_r   <= last_r;
      res_active_r <= 1'b1;
    end
    if (load_out) begin
      out_sample_r <= res_sample_r;
      out_last_r   <= res_last_r;
      out_active_r <= res_active_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;
  assign out_active = out_active_r;

`ifndef NO_ASSERTIONS
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_active |-> out_sample == '0 && !out_last)
    else $error("idle item carries a nonzero sample or last");

  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample <= 16'sd26000 && out_sample >= -16'sd26000)
    else $error("sample magnitude out of range");

  a_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_busy && !div_start || !div_busy)
    else $error("arithmetic unit restarted while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE)
    else $error("accepted item left no work in flight");
`endif

endmodule

// ----- test/tone_scoreboard_pkg.sv -----
// Sample predictor and expected-frame scoreboard for the enveloped sine tone generator.
package tone_scoreboard_pkg;

  localparam int unsigned QUARTER_DEPTH = 256;
  localparam int unsigned ATTACK_LIMIT = 96;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TONE_GAIN = 64'd26000;
  localparam logic [esg_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
    logic               active;
  } tone_frame_t;

  class tone_scoreboard;
    int unsigned quarter_sine [QUARTER_DEPTH+1];
    logic [31:0] phase_step;
    logic [15:0] tone_frames;
    logic [15:0] amplitude;
    logic [31:0] phase_acc;
    logic [15:0] frame_idx;
    bit          tone_on;
    tone_frame_t pending_frames [$];
    int unsigned mismatches;

    function new();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned q;
      longint          sum;
      for (int k = 0; k <= QUARTER_DEPTH; k++) begin
        x = (HALF_PI_Q30 * 64'(k)) / QUARTER_DEPTH;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int n = 1; n <= 5; n++) begin
          term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) begin
            sum -= longint'(term);
          end else begin
            sum += longint'(term);
          end
        end
        if (sum < 0) begin
          sum = 0;
        end
        if (sum > (longint'(1) << 30)) begin
          sum = longint'(1) << 30;
        end
        q = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (q > 64'd32767) begin
          q = 64'd32767;
        end
        quarter_sine[k] = int'(q);
      end
      phase_step = '0;
      tone_frames = '0;
      amplitude = '0;
      phase_acc = '0;
      frame_idx = '0;
      tone_on = 1'b0;
      mismatches = 0;
    endfunction

    function int sine_at(logic [31:0] ph);
      int unsigned pos;
      int          v;
      pos = int'((64'(ph[29:0]) * QUARTER_DEPTH) >> 30);
      if (pos > QUARTER_DEPTH) begin
        pos = QUARTER_DEPTH;
      end
      v = ph[30] ? int'(quarter_sine[QUARTER_DEPTH - pos]) : int'(quarter_sine[pos]);
      return ph[31] ? -v : v;
    endfunction

    function longint unsigned envelope_at(int unsigned n, int unsigned frames);
      int unsigned attack;
      attack = frames / 4;
      if (attack > ATTACK_LIMIT) begin
        attack = ATTACK_LIMIT;
      end
      if (n < attack) begin
        return (64'(n) << 16) / 64'(attack);
      end
      return (64'(frames - n) << 16) / 64'(frames - attack);
    endfunction

    function void write_reg(logic [esg_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        esg_pkg::REG_PHASE_STEP: phase_step = data;
        esg_pkg::REG_TONE_FRAMES: tone_frames = data[15:0];
        esg_pkg::REG_AMPLITUDE: amplitude = data[15:0];
        default: ;
      endcase
    endfunction

    function void note_tick(bit start_req);
      tone_frame_t     f;
      int              s;
      longint unsigned mag;
      f = '0;
      if (start_req) begin
        phase_acc = '0;
        frame_idx = '0;
        tone_on = tone_frames != 0;
      end
      if (tone_on && frame_idx >= tone_frames) begin
        tone_on = 1'b0;
      end
      if (tone_on) begin
        s = sine_at(phase_acc);
        mag = (64'(s < 0 ? -s : s) * envelope_at(32'(frame_idx), 32'(tone_frames))
               * 64'(amplitude) * TONE_GAIN) >> 47;
        f.sample = (s < 0) ? 16'(-mag) : 16'(mag);
        f.last = (32'(frame_idx) + 32'd1) == 32'(tone_frames);
        f.active = 1'b1;
        phase_acc += phase_step;
        frame_idx += 16'd1;
        if (f.last) begin
          tone_on = 1'b0;
        end
      end
      pending_frames.push_back(f);
    endfunction

    function void check_sample(logic signed [15:0] smp, logic lst, logic act);
      tone_frame_t f;
      if (pending_frames.size() == 0) begin
        $error("unexpected result: sample %0d last %0b active %0b", smp, lst, act);
        mismatches++;
        return;
      end
      f = pending_frames.pop_front();
      if (smp !== f.sample) begin
        $error("sample: expected %0d, actual %0d", f.sample, smp);
        mismatches++;
      end
      if (lst !== f.last) begin
        $error("last: expected %0b, actual %0b", f.last, lst);
        mismatches++;
      end
      if (act !== f.active) begin
        $error("active: expected %0b, actual %0b", f.active, act);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ----- test/enveloped_sine_tone_generator_top_test.sv -----
// Randomized and directed testbench of the enveloped sine tone generator top level.
module enveloped_sine_tone_generator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tone_scoreboard_pkg::*;

  localparam int unsigned RANDOM_TICKS = 1600;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 120;

  logic                               clk = 1'b0;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_stall;
  logic                               in_start_req;
  logic                               out_valid;
  logic                               out_stall;
  logic signed [esg_pkg::SAMPLE_W-1:0] out_sample;
  logic                               out_last;
  logic                               out_active;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [esg_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [esg_pkg::CFG_DATA_W-1:0]     cfg_data;

  tone_scoreboard sb;
  bit             send_calm = 1'b0;
  bit             take_calm = 1'b0;
  int unsigned    cycles = 0;
  int unsigned    random_ticks = 0;

  enveloped_sine_tone_generator_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_start_req (in_start_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_sample   (out_sample),
    .out_last     (out_last),
    .out_active   (out_active),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** enveloped_sine_tone_generator_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_sample(out_sample, out_last, out_active);
    end
  end

  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      hold = take_calm ? 0 : $urandom_range(0, 3);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_item(bit start_req);
    int unsigned gap;
    gap = send_calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_start_req <= start_req;
    do @(posedge clk); while (in_stall);
    sb.note_tick(start_req);
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [esg_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_frames.size() != 0) @(negedge clk);
  endtask

  task automatic random_phase();
    int unsigned len;
    bit          tidy;
    bit          start_req;
    logic [31:0] step;
    logic [15:0] frames;
    logic [15:0] gain;
    send_calm = $urandom_range(0, 4) == 0;
    take_calm = $urandom_range(0, 4) == 0;
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 7))
        0: step = '0;
        1: step = '1;
        2: step = 32'h4000_0000;
        3: step = $urandom_range(1, 32'h0100_0000);
        default: step = $urandom;
      endcase
      write_cfg(esg_pkg::REG_PHASE_STEP, step);
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 15))
        0: frames = '0;
        1: frames = '1;
        2: frames = 16'($urandom);
        3, 4: frames = 16'($urandom_range(49, 400));
        default: frames = 16'($urandom_range(1, 48));
      endcase
      write_cfg(esg_pkg::REG_TONE_FRAMES, {16'($urandom), frames});
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 7))
        0: gain = '0;
        1: gain = '1;
        default: gain = 16'($urandom);
      endcase
      write_cfg(esg_pkg::REG_AMPLITUDE, {16'($urandom), gain});
    end
    if ($urandom_range(0, 9) == 0) begin
      write_cfg(REG_NONE, $urandom);
    end
    tidy = $urandom_range(0, 4) != 0;
    len = $urandom_range(4, 60);
    for (int i = 0; i < len; i++) begin
      if (tidy) begin
        start_req = (i == 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 40) == 0;
      end else begin
        start_req = 1'($urandom_range(0, 1));
      end
      send_item(start_req);
    end
    random_ticks += len;
    drain();
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_start_req = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = esg_pkg::REG_PHASE_STEP;
    cfg_data = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(1'b0);
    send_item(1'b1);
    drain();

    write_cfg(esg_pkg::REG_PHASE_STEP, 32'h4000_0000);
    write_cfg(esg_pkg::REG_TONE_FRAMES, 32'd5);
    write_cfg(esg_pkg::REG_AMPLITUDE, 32'h0000_FFFF);
    send_item(1'b1);
    repeat (5) send_item(1'b0);
    drain();

    write_cfg(esg_pkg::REG_PHASE_STEP, 32'h0100_0000);
    write_cfg(esg_pkg::REG_TONE_FRAMES, 32'd8);
    send_item(1'b1);
    repeat (3) send_item(1'b0);
    send_item(1'b1);
    repeat (2) send_item(1'b0);
    drain();

    write_cfg(esg_pkg::REG_TONE_FRAMES, 32'd2);
    send_item(1'b0);
    drain();

    write_cfg(esg_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
    write_cfg(esg_pkg::REG_TONE_FRAMES, 32'hFFFF_FFFF);
    write_cfg(esg_pkg::REG_AMPLITUDE, 32'hFFFF_FFFF);
    write_cfg(REG_NONE, 32'hFFFF_FFFF);
    send_item(1'b1);
    repeat (2) send_item(1'b0);
    drain();
    write_cfg(esg_pkg::REG_AMPLITUDE, 32'd0);
    send_item(1'b0);
    drain();
    write_cfg(esg_pkg::REG_AMPLITUDE, 32'h0000_8000);
    write_cfg(esg_pkg::REG_TONE_FRAMES, 32'd0);
    send_item(1'b0);
    drain();

    while (random_ticks < RANDOM_TICKS) begin
      random_phase();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("** enveloped_sine_tone_generator_top: PASSED **");
    end else begin
      $display("** enveloped_sine_tone_generator_top: FAILED **");
    end
    $finish;
  end

endmodule
